/* hw/rtl/swerve_forward_kinematics_core_defines.svh */
// assertion macros for the swerve forward kinematics core
// expects clk and rst_n in the scope where a macro is used
`ifndef SWERVE_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define SWERVE_FORWARD_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FKC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fkc same-cycle check failed");

// next-cycle implication, disabled in reset
`define FKC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fkc next-cycle check failed");

`endif

/* hw/rtl/fkc_pkg.sv */
// shared constants, types and functions of the swerve forward kinematics core
// no dependencies
`timescale 1ns / 1ps

package fkc_pkg;

  localparam int SPEED_BITS    = 16;
  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  localparam int GUARD = 16;
  localparam int NST   = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int IDXW  = 5;
  localparam int AW    = 32;
  localparam int XW    = SPEED_BITS + GUARD + 2;
  localparam int SW    = XW + 2;
  localparam int ZW    = 34;
  localparam int VW    = 36;
  localparam int DVW   = 25;
  localparam int NW    = SW + 1;
  localparam int QB    = SPEED_BITS;
  localparam int QIW   = $clog2(QB);
  localparam int RW    = ((NW > DVW + QB) ? NW : DVW + QB) + 1;

  localparam logic [30:0] KINV = 31'd652032874;

  // register indexes
  localparam logic [1:0] REG_WHEELBASE = 2'd0;
  localparam logic [1:0] REG_TRACK     = 2'd1;
  localparam logic [1:0] REG_DIAMETER  = 2'd2;

  // per-cell control
  typedef struct packed {
    logic            en;
    logic [IDXW-1:0] idx;
  } fkc_cell_ctl_t;

  typedef struct packed {
    logic           en;
    logic [QIW-1:0] bit_idx;
  } fkc_div_ctl_t;

  // arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [AW-1:0] atan_val(input logic [IDXW-1:0] i);
    logic [AW-1:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933405;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10680350;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41721;
      5'd15: r = 32'd20860;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2607;
      5'd19: r = 32'd1303;
      5'd20: r = 32'd651;
      5'd21: r = 32'd325;
      5'd22: r = 32'd162;
      5'd23: r = 32'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp a wide signed value to the output range
  function automatic logic signed [SPEED_BITS-1:0] sat_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = {{(SW-SPEED_BITS+1){1'b0}}, {(SPEED_BITS-1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SPEED_BITS-1:0];
    end else if (v < lo) begin
      return lo[SPEED_BITS-1:0];
    end
    return v[SPEED_BITS-1:0];
  endfunction

endpackage

/* hw/rtl/fkc_in_if.sv */
// input channel of the swerve forward kinematics core: four wheel speeds and angles
// depends on fkc_pkg
`timescale 1ns / 1ps

interface fkc_in_if import fkc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SPEED_BITS-1:0] speed_front_left;
  logic signed [ANGLE_BITS-1:0] angle_front_left;
  logic signed [SPEED_BITS-1:0] speed_front_right;
  logic signed [ANGLE_BITS-1:0] angle_front_right;
  logic signed [SPEED_BITS-1:0] speed_rear_left;
  logic signed [ANGLE_BITS-1:0] angle_rear_left;
  logic signed [SPEED_BITS-1:0] speed_rear_right;
  logic signed [ANGLE_BITS-1:0] angle_rear_right;

  modport source (
    output valid, speed_front_left, angle_front_left, speed_front_right, angle_front_right,
           speed_rear_left, angle_rear_left, speed_rear_right, angle_rear_right,
    input  ready
  );
  modport sink (
    input  valid, speed_front_left, angle_front_left, speed_front_right, angle_front_right,
           speed_rear_left, angle_rear_left, speed_rear_right, angle_rear_right,
    output ready
  );
endinterface

/* hw/rtl/fkc_out_if.sv */
// result channel of the swerve forward kinematics core: body velocity
// depends on fkc_pkg
`timescale 1ns / 1ps

interface fkc_out_if import fkc_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [SPEED_BITS-1:0] forward_velocity;
  logic signed [SPEED_BITS-1:0] strafe_velocity;
  logic signed [SPEED_BITS-1:0] angular_velocity;

  modport source (output valid, forward_velocity, strafe_velocity, angular_velocity,
                  input ready);
  modport sink (input valid, forward_velocity, strafe_velocity, angular_velocity,
                output ready);
endinterface

/* hw/rtl/fkc_vec_cell.sv */
// one vectoring step of the corner angle cordic chain
// depends on fkc_pkg
`timescale 1ns / 1ps

module fkc_vec_cell import fkc_pkg::*; (
  input  logic                 clk,
  input  fkc_cell_ctl_t        ctl,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [VW-1:0] x_r,
  output logic signed [VW-1:0] y_r,
  output logic signed [ZW-1:0] z_r
);
  logic signed [VW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [ZW-1:0] at, z_nxt;

  assign dx = y_in >>> ctl.idx;
  assign dy = x_in >>> ctl.idx;
  assign at = {{(ZW-AW){1'b0}}, atan_val(ctl.idx)};

  // drive y toward zero
  always_comb begin
    if (!y_in[VW-1]) begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + at;
    end else begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - at;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

/* hw/rtl/fkc_rot_cell.sv */
// one rotation step of the wheel vector cordic chain
// depends on fkc_pkg
`timescale 1ns / 1ps

module fkc_rot_cell import fkc_pkg::*; (
  input  logic                 clk,
  input  fkc_cell_ctl_t        ctl,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_r,
  output logic signed [XW-1:0] y_r,
  output logic signed [ZW-1:0] z_r
);
  logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [ZW-1:0] at, z_nxt;

  assign dx = y_in >>> ctl.idx;
  assign dy = x_in >>> ctl.idx;
  assign at = {{(ZW-AW){1'b0}}, atan_val(ctl.idx)};

  // drive residual angle toward zero
  always_comb begin
    if (!z_in[ZW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - at;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + at;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end
endmodule

/* hw/rtl/fkc_div_cell.sv */
// one restoring quotient bit of the angular rate divider
// depends on fkc_pkg
`timescale 1ns / 1ps

module fkc_div_cell import fkc_pkg::*; (
  input  logic            clk,
  input  fkc_div_ctl_t    ctl,
  input  logic [RW-1:0]   rem_in,
  input  logic [DVW-1:0]  dv_in,
  input  logic [QB-1:0]   q_in,
  output logic [RW-1:0]   rem_r,
  output logic [DVW-1:0]  dv_r,
  output logic [QB-1:0]   q_r
);
  logic [RW-1:0] trial, rem_nxt;
  logic [QB-1:0] q_nxt;

  assign trial = RW'(dv_in) << ctl.bit_idx;

  // subtract the shifted divisor when it fits
  always_comb begin
    rem_nxt = rem_in;
    q_nxt   = q_in;
    if (rem_in >= trial) begin
      rem_nxt = rem_in - trial;
      q_nxt[ctl.bit_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      rem_r <= rem_nxt;
      dv_r  <= dv_in;
      q_r   <= q_nxt;
    end
  end
endmodule

/* hw/rtl/swerve_forward_kinematics_core.sv */
// top level of the swerve forward kinematics core: apb registers, cordic chains, divider
// depends on fkc_pkg, fkc_in_if, fkc_out_if, the three cell modules and the defines header
`timescale 1ns / 1ps
`include "swerve_forward_kinematics_core_defines.svh"

// Usage
// in_if carries one beat per set of four wheel speeds and steering angles; out_if returns
// one beat per input beat with forward, strafe and angular velocity, in order.
// Registers: wheelbase_length at 0x0, track_width at 0x4, turning_diameter at 0x8 over
// the apb port (pready always high); write them only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled, set by the fully pipelined cell chains.
// Path from input accept to output valid: input register, reciprocal-gain multiply,
// corner angle vectoring chain, pre-rotation, eight-lane rotation chain, sum, divider
// setup, one divider cell per quotient bit, output register.
// Stall: when out_if.ready is low and the output register is full, the chain keeps
// moving until its last stage holds a beat, then the whole chain and in_if.ready hold.
// Reset: clears all valid bits and loads the register reset values (256, 256, 362).
module swerve_forward_kinematics_core import fkc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fkc_in_if.sink      in_if,
  fkc_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int TOT = 5 + 2 * NST + QB;

  // configuration registers
  logic [15:0] len_r, trk_r, dia_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= 16'd256;
      trk_r <= 16'd256;
      dia_r <= 16'd362;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WHEELBASE: len_r <= pwdata[15:0];
        REG_TRACK:     trk_r <= pwdata[15:0];
        REG_DIAMETER:  dia_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WHEELBASE: prdata = {16'd0, len_r};
      REG_TRACK:     prdata = {16'd0, trk_r};
      REG_DIAMETER:  prdata = {16'd0, dia_r};
      default:       prdata = '0;
    endcase
  end

  // pipeline control
  logic           adv, acc;
  logic [TOT-1:0] vld_r;
  logic           out_valid_r;

  assign adv         = !vld_r[TOT-1] || !out_valid_r || out_if.ready;
  assign in_if.ready = adv;
  assign acc         = in_if.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[TOT-2:0], acc};
    end
  end

  // input register
  logic signed [SPEED_BITS-1:0] spd0_r [4];
  logic signed [ANGLE_BITS-1:0] ang0_r [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      spd0_r[0] <= in_if.speed_front_left;
      spd0_r[1] <= in_if.speed_front_right;
      spd0_r[2] <= in_if.speed_rear_left;
      spd0_r[3] <= in_if.speed_rear_right;
      ang0_r[0] <= in_if.angle_front_left;
      ang0_r[1] <= in_if.angle_front_right;
      ang0_r[2] <= in_if.angle_rear_left;
      ang0_r[3] <= in_if.angle_rear_right;
    end
  end

  // reciprocal gain multiply and vectoring start
  logic signed [SPEED_BITS+30:0] prod [4];
  logic signed [XW-1:0]          x0p_r [0:NST][4];
  logic [AW-1:0]                 angp_r [0:NST][4];
  logic signed [VW-1:0]          vx [0:NST];
  logic signed [VW-1:0]          vy [0:NST];
  logic signed [ZW-1:0]          vz [0:NST];
  logic signed [VW-1:0]          vx1_r, vy1_r;
  logic signed [ZW-1:0]          vz1_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = spd0_r[k] * $signed({1'b0, KINV});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        x0p_r[0][k]  <= XW'(prod[k] >>> (30 - GUARD));
        angp_r[0][k] <= {ang0_r[k], {(AW-ANGLE_BITS){1'b0}}};
      end
      vx1_r <= {{(VW-32){1'b0}}, len_r, 16'd0};
      vy1_r <= {{(VW-32){1'b0}}, trk_r, 16'd0};
      vz1_r <= '0;
    end
  end

  assign vx[0] = vx1_r;
  assign vy[0] = vy1_r;
  assign vz[0] = vz1_r;

  // corner angle vectoring chain, wheel data rides alongside
  for (genvar i = 0; i < NST; i++) begin : g_vec
    fkc_cell_ctl_t vctl;
    assign vctl.en  = adv;
    assign vctl.idx = IDXW'(i);

    fkc_vec_cell u_vec (
      .clk (clk), .ctl (vctl),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_r (vx[i+1]), .y_r(vy[i+1]), .z_r(vz[i+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        x0p_r[i+1]  <= x0p_r[i];
        angp_r[i+1] <= angp_r[i];
      end
    end
  end

  // corner offsets and quadrant pre-rotation for all eight lanes
  logic [AW-1:0]        p_ang;
  logic [AW-1:0]        phi [4];
  logic [AW-1:0]        lt [8];
  logic [AW-1:0]        lt2 [8];
  logic                 flip [8];
  logic signed [XW-1:0] rx [0:NST][0:7];
  logic signed [XW-1:0] ry [0:NST][0:7];
  logic signed [ZW-1:0] rz [0:NST][0:7];
  logic signed [XW-1:0] rx0_r [8];
  logic signed [ZW-1:0] rz0_r [8];

  assign p_ang  = (len_r == 16'd0 && trk_r == 16'd0) ? '0 : vz[NST][AW-1:0];
  assign phi[0] = '0 - p_ang;
  assign phi[1] = p_ang;
  assign phi[2] = p_ang - {1'b1, {(AW-1){1'b0}}};
  assign phi[3] = {1'b1, {(AW-1){1'b0}}} - p_ang;

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      lt[l]   = (l % 2 == 0) ? angp_r[NST][l/2] : angp_r[NST][l/2] - phi[l/2];
      flip[l] = lt[l][AW-1] ^ lt[l][AW-2];
      lt2[l]  = flip[l] ? {~lt[l][AW-1], lt[l][AW-2:0]} : lt[l];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 8; l++) begin
        rx0_r[l] <= flip[l] ? -x0p_r[NST][l/2] : x0p_r[NST][l/2];
        rz0_r[l] <= {{(ZW-AW){lt2[l][AW-1]}}, lt2[l]};
      end
    end
  end

  // rotation chain, eight lanes per stage
  for (genvar l = 0; l < 8; l++) begin : g_lane
    assign rx[0][l] = rx0_r[l];
    assign ry[0][l] = '0;
    assign rz[0][l] = rz0_r[l];
    for (genvar i = 0; i < NST; i++) begin : g_rot
      fkc_cell_ctl_t rctl;
      assign rctl.en  = adv;
      assign rctl.idx = IDXW'(i);

      fkc_rot_cell u_rot (
        .clk (clk), .ctl (rctl),
        .x_in(rx[i][l]), .y_in(ry[i][l]), .z_in(rz[i][l]),
        .x_r (rx[i+1][l]), .y_r(ry[i+1][l]), .z_r(rz[i+1][l])
      );
    end
  end

  // wheel sums
  logic signed [SW-1:0] fsum_r, ssum_r, osum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      fsum_r <= SW'(rx[NST][0]) + SW'(rx[NST][2]) + SW'(rx[NST][4]) + SW'(rx[NST][6]);
      ssum_r <= SW'(ry[NST][0]) + SW'(ry[NST][2]) + SW'(ry[NST][4]) + SW'(ry[NST][6]);
      osum_r <= SW'(ry[NST][1]) + SW'(ry[NST][3]) + SW'(ry[NST][5]) + SW'(ry[NST][7]);
    end
  end

  // divider setup: q = (|omega| + 256 d) / (512 d)
  localparam logic signed [SW-1:0] RND = SW'(1) << (GUARD + 1);

  logic signed [SW-1:0]         fsh, ssh;
  logic [SW-1:0]                mag;
  logic [15:0]                  d_eff;
  logic [NW-1:0]                numr;
  logic [DVW-1:0]               dv0;
  logic signed [SPEED_BITS-1:0] fwdd_r [0:QB];
  logic signed [SPEED_BITS-1:0] strd_r [0:QB];
  logic                         negd_r [0:QB];
  logic                         ovfd_r [0:QB];
  logic [RW-1:0]                rem [0:QB];
  logic [DVW-1:0]               dvs [0:QB];
  logic [QB-1:0]                qs [0:QB];
  logic [RW-1:0]                rem0_r;
  logic [DVW-1:0]               dv0_r;

  assign fsh   = (fsum_r + RND) >>> (GUARD + 2);
  assign ssh   = (ssum_r + RND) >>> (GUARD + 2);
  assign mag   = osum_r[SW-1] ? SW'(-osum_r) : SW'(osum_r);
  assign d_eff = (dia_r == 16'd0) ? 16'd1 : dia_r;
  assign numr  = NW'(mag) + NW'({d_eff, 8'd0});
  assign dv0   = {d_eff, 9'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      fwdd_r[0] <= sat_out(fsh);
      strd_r[0] <= sat_out(ssh);
      negd_r[0] <= osum_r[SW-1];
      ovfd_r[0] <= RW'(numr) >= (RW'(dv0) << QB);
      rem0_r    <= RW'(numr);
      dv0_r     <= dv0;
    end
  end

  assign rem[0] = rem0_r;
  assign dvs[0] = dv0_r;
  assign qs[0]  = '0;

  // divider chain, most significant quotient bit first
  for (genvar j = 0; j < QB; j++) begin : g_div
    fkc_div_ctl_t dctl;
    assign dctl.en      = adv;
    assign dctl.bit_idx = QIW'(QB - 1 - j);

    fkc_div_cell u_div (
      .clk   (clk), .ctl(dctl),
      .rem_in(rem[j]), .dv_in(dvs[j]), .q_in(qs[j]),
      .rem_r (rem[j+1]), .dv_r(dvs[j+1]), .q_r(qs[j+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        fwdd_r[j+1] <= fwdd_r[j];
        strd_r[j+1] <= strd_r[j];
        negd_r[j+1] <= negd_r[j];
        ovfd_r[j+1] <= ovfd_r[j];
      end
    end
  end

  // signed, saturated angular rate
  logic signed [SPEED_BITS-1:0] ang_res;
  logic [QB-1:0]                qf;

  assign qf = qs[QB];

  always_comb begin
    if (negd_r[QB]) begin
      if (ovfd_r[QB] || qf > {1'b1, {(QB-1){1'b0}}}) begin
        ang_res = {1'b1, {(SPEED_BITS-1){1'b0}}};
      end else begin
        ang_res = SPEED_BITS'(-qf);
      end
    end else begin
      if (ovfd_r[QB] || qf[QB-1]) begin
        ang_res = {1'b0, {(SPEED_BITS-1){1'b1}}};
      end else begin
        ang_res = SPEED_BITS'(qf);
      end
    end
  end

  // output register
  logic signed [SPEED_BITS-1:0] out_fwd_r, out_str_r, out_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      if (adv && vld_r[TOT-1]) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld_r[TOT-1]) begin
      out_fwd_r <= fwdd_r[QB];
      out_str_r <= strd_r[QB];
      out_ang_r <= ang_res;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.forward_velocity = out_fwd_r;
  assign out_if.strafe_velocity  = out_str_r;
  assign out_if.angular_velocity = out_ang_r;

  // checks
  `FKC_ASSERT_NXT(a_accept_enters, acc, vld_r[0])
  `FKC_ASSERT_IMP(a_out_from_chain, $rose(out_valid_r), $past(vld_r[TOT-1]))
  `FKC_ASSERT_NXT(a_stall_holds_last, !adv, vld_r[TOT-1])

endmodule
